// ----- design/assert_macros.svh -----
// Assertion helpers clocked on clk; MLWF_ASSERT is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MLWF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mlwf check failed");
`define MLWF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("mlwf check failed");
`else
`define MLWF_ASSERT(lbl, prop)
`define MLWF_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ----- design/mlwf_pkg.sv -----
package mlwf_pkg;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_WINDOW = 7;
  localparam int MAX_HEIGHT = 4096;
  localparam int LINE_ROWS  = MAX_WINDOW - 1;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int WORD_W     = 24 * LINE_ROWS;
  localparam int DIV_STEPS  = 14;
  localparam int CNT_W      = 4;

  // configuration register indexes
  localparam logic [2:0] CFG_IMAGE_WIDTH   = 3'd0;
  localparam logic [2:0] CFG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [2:0] CFG_FILTER_MODE   = 3'd2;
  localparam logic [2:0] CFG_WINDOW_WIDTH  = 3'd3;
  localparam logic [2:0] CFG_WINDOW_HEIGHT = 3'd4;

  typedef logic [23:0] pix_t;

  typedef struct packed {
    logic accept;
    logic load;
    logic rot;
    logic div_init;
    logic div_step;
    logic lap;
    logic out_load;
  } mlwf_cmd_t;

  typedef struct packed {
    logic emit;
    logic lap_mode;
    logic rot_last;
    logic div_last;
  } mlwf_sts_t;
endpackage

// ----- design/mlwf_ctrl.sv -----
module mlwf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_acc,
  input  logic                out_full,
  input  mlwf_pkg::mlwf_sts_t sts,
  output mlwf_pkg::mlwf_cmd_t cmd,
  output logic                idle
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_DIVI = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_LAP  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd.accept = 1'b1;
          state_nxt  = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load = 1'b1;
        if (!sts.emit) state_nxt = S_IDLE;
        else if (sts.lap_mode) state_nxt = S_LAP;
        else state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.rot = 1'b1;
        if (sts.rot_last) state_nxt = S_DIVI;
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_DONE;
      end
      S_LAP: begin
        cmd.lap   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_full) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign idle = (state_r == S_IDLE);
endmodule

// ----- design/mlwf_dp.sv -----
module mlwf_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  mlwf_pkg::mlwf_cmd_t cmd,
  output mlwf_pkg::mlwf_sts_t sts,
  input  logic [10:0]         eff_width,
  input  logic [12:0]         eff_height,
  input  logic                mode,
  input  logic [2:0]          win_w,
  input  logic [2:0]          win_h,
  input  logic [7:0]          in_red,
  input  logic [7:0]          in_green,
  input  logic [7:0]          in_blue,
  output logic [11:0]         res_row,
  output logic [9:0]          res_col,
  output logic [7:0]          res_red,
  output logic [7:0]          res_green,
  output logic [7:0]          res_blue
);
  localparam int MW = mlwf_pkg::MAX_WINDOW;

  logic [mlwf_pkg::WORD_W-1:0] mem [mlwf_pkg::MAX_WIDTH];
  logic [mlwf_pkg::WORD_W-1:0] rd_r;
  mlwf_pkg::pix_t              pix_r;
  mlwf_pkg::pix_t              win_r [MW][MW];
  logic [9:0]  col_cnt_r;
  logic [11:0] row_cnt_r;
  logic [9:0]  c_r;
  logic [11:0] r_r;
  logic [2:0]  kx_r, ky_r;
  logic        mode_r;
  logic [5:0]  area_r;
  logic [11:0] row_r;
  logic [9:0]  col_r;
  logic [mlwf_pkg::CNT_W-1:0] cnt_r;
  logic [13:0] acc_r [3];
  logic [13:0] quo_r [3];
  logic [5:0]  rem_r [3];
  logic [7:0]  res_r [3];

  logic [10:0] col_inc;
  logic [12:0] row_inc;
  logic [2:0]  kx_cfg, ky_cfg, kxm1, kym1, ox, oy;
  logic        early;
  logic [11:0] i_pos;
  logic [9:0]  j_pos;
  logic [11:0] j_end;
  logic [12:0] i_end;

  // window size at accept
  always_comb begin
    kx_cfg = mode ? 3'd3 : ((win_w == 3'd0) ? 3'd1 : win_w);
    ky_cfg = mode ? 3'd3 : ((win_h == 3'd0) ? 3'd1 : win_h);
    col_inc = {1'b0, col_cnt_r} + 11'd1;
    row_inc = {1'b0, row_cnt_r} + 13'd1;
  end

  // raster counters and per-item latches
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (cmd.accept) begin
      if (col_inc >= eff_width) begin
        col_cnt_r <= '0;
        row_cnt_r <= (row_inc >= eff_height) ? 12'd0 : row_inc[11:0];
      end else begin
        col_cnt_r <= col_inc[9:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix_r  <= {in_blue, in_green, in_red};
      c_r    <= col_cnt_r;
      r_r    <= row_cnt_r;
      kx_r   <= kx_cfg;
      ky_r   <= ky_cfg;
      mode_r <= mode;
      area_r <= {3'd0, kx_cfg} * {3'd0, ky_cfg};
      rd_r   <= mem[col_cnt_r];
    end
  end

  // line store update: newest row enters slot zero
  always_ff @(posedge clk) begin
    if (cmd.load) mem[c_r] <= {rd_r[mlwf_pkg::WORD_W-25:0], pix_r};
  end

  // centre position and border test
  always_comb begin
    kxm1  = kx_r - 3'd1;
    kym1  = ky_r - 3'd1;
    ox    = kx_r >> 1;
    oy    = ky_r >> 1;
    early = (r_r < {9'd0, kym1}) || (c_r < {7'd0, kxm1});
    i_pos = r_r - {9'd0, kym1} + {9'd0, oy};
    j_pos = c_r - {7'd0, kxm1} + {7'd0, ox};
    j_end = {2'b0, j_pos} + {9'd0, ox};
    i_end = {1'b0, i_pos} + {10'd0, oy};
  end

  assign sts.emit     = !early && (j_end < {1'b0, eff_width}) && (i_end < eff_height);
  assign sts.lap_mode = mode_r;
  assign sts.rot_last = (cnt_r == mlwf_pkg::CNT_W'(MW - 1));
  assign sts.div_last = (cnt_r == mlwf_pkg::CNT_W'(mlwf_pkg::DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row_r <= i_pos;
      col_r <= j_pos;
    end
  end

  // step counter for rotation and division
  always_ff @(posedge clk) begin
    if (cmd.load || cmd.div_init) cnt_r <= '0;
    else if (cmd.rot || cmd.div_step) cnt_r <= cnt_r + mlwf_pkg::CNT_W'(1);
  end

  // window: shift in new column on load, full rotation while summing
  // (rotation brings the next older column into slot zero)
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int ci = MW - 1; ci > 0; ci--) begin
        for (int k = 0; k < MW; k++) win_r[ci][k] <= win_r[ci-1][k];
      end
      win_r[0][0] <= pix_r;
      for (int k = 1; k < MW; k++) win_r[0][k] <= rd_r[24*(k-1) +: 24];
    end else if (cmd.rot) begin
      for (int ci = 0; ci < MW - 1; ci++) begin
        for (int k = 0; k < MW; k++) win_r[ci][k] <= win_r[ci+1][k];
      end
      for (int k = 0; k < MW; k++) win_r[MW-1][k] <= win_r[0][k];
    end
  end

  // column sums of the leading column
  logic [10:0] col_sum [3];
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      col_sum[ch] = '0;
      for (int b = 0; b < MW; b++) begin
        if (3'(b) < ky_r) col_sum[ch] = col_sum[ch] + {3'd0, win_r[0][b][8*ch +: 8]};
      end
    end
  end

  // restoring divider, one quotient bit per step
  logic [6:0] trial [3];
  always_comb begin
    for (int ch = 0; ch < 3; ch++) trial[ch] = {rem_r[ch], quo_r[ch][13]};
  end

  // Laplacian: 5*centre minus four neighbours, clamped
  logic signed [11:0] lap_v [3];
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      lap_v[ch] = $signed({4'd0, win_r[1][1][8*ch +: 8]}) * 12'sd5
                - $signed({4'd0, win_r[1][0][8*ch +: 8]})
                - $signed({4'd0, win_r[1][2][8*ch +: 8]})
                - $signed({4'd0, win_r[0][1][8*ch +: 8]})
                - $signed({4'd0, win_r[2][1][8*ch +: 8]});
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      if (cmd.load) acc_r[ch] <= '0;
      else if (cmd.rot && ({1'b0, cnt_r} < {2'b0, kx_r}))
        acc_r[ch] <= acc_r[ch] + {3'd0, col_sum[ch]};
      if (cmd.div_init) begin
        quo_r[ch] <= acc_r[ch];
        rem_r[ch] <= '0;
      end else if (cmd.div_step) begin
        if (trial[ch] >= {1'b0, area_r}) begin
          rem_r[ch] <= 6'(trial[ch] - {1'b0, area_r});
          quo_r[ch] <= {quo_r[ch][12:0], 1'b1};
        end else begin
          rem_r[ch] <= trial[ch][5:0];
          quo_r[ch] <= {quo_r[ch][12:0], 1'b0};
        end
      end
      if (cmd.lap) begin
        if (lap_v[ch] < 12'sd0) res_r[ch] <= 8'd0;
        else if (lap_v[ch] > 12'sd255) res_r[ch] <= 8'd255;
        else res_r[ch] <= lap_v[ch][7:0];
      end else if (cmd.div_step && sts.div_last) begin
        res_r[ch] <= {quo_r[ch][6:0], (trial[ch] >= {1'b0, area_r})};
      end
    end
  end

  assign res_row   = row_r;
  assign res_col   = col_r;
  assign res_red   = res_r[0];
  assign res_green = res_r[1];
  assign res_blue  = res_r[2];
endmodule

// ----- design/mean_and_laplacian_window_filter.sv -----
// channel | direction | handshake          | payload
// in_     | input     | in_valid/in_stall  | in_red, in_green, in_blue
// out_    | output    | out_valid/out_stall| out_row, out_col, out_red/green/blue
// cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
// A pixel that completes no window goes through accept and the line store update only.
// Mean mode: accept, line store update, 7 rotation/accumulate steps, divider init,
// 14 divider steps, output load. Laplacian mode: accept, line store update,
// Laplacian, output load. One pixel is in work at a time.
// Reset (synchronous, rst_n low) clears counters, state and config to defaults.
// A finished beat waits in the output register while the next pixel is taken.
`include "assert_macros.svh"
module mean_and_laplacian_window_filter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_row,
  output logic [9:0]  out_col,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  logic [10:0] img_w_r;
  logic [12:0] img_h_r;
  logic        mode_r;
  logic [2:0]  win_w_r, win_h_r;
  logic [10:0] eff_width;
  logic [12:0] eff_height;
  logic        idle, in_acc, out_full;
  mlwf_pkg::mlwf_cmd_t cmd;
  mlwf_pkg::mlwf_sts_t sts;
  logic [11:0] res_row;
  logic [9:0]  res_col;
  logic [7:0]  res_red, res_green, res_blue;
  logic        out_valid_r;
  logic [11:0] out_row_r;
  logic [9:0]  out_col_r;
  logic [7:0]  out_red_r, out_green_r, out_blue_r;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= 11'd640;
      img_h_r <= 13'd480;
      mode_r  <= 1'b0;
      win_w_r <= 3'd3;
      win_h_r <= 3'd3;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mlwf_pkg::CFG_IMAGE_WIDTH:   img_w_r <= cfg_data[10:0];
        mlwf_pkg::CFG_IMAGE_HEIGHT:  img_h_r <= cfg_data;
        mlwf_pkg::CFG_FILTER_MODE:   mode_r  <= cfg_data[0];
        mlwf_pkg::CFG_WINDOW_WIDTH:  win_w_r <= cfg_data[2:0];
        mlwf_pkg::CFG_WINDOW_HEIGHT: win_h_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // effective frame size
  always_comb begin
    if (img_w_r == 11'd0) eff_width = 11'd1;
    else if (img_w_r > 11'(mlwf_pkg::MAX_WIDTH)) eff_width = 11'(mlwf_pkg::MAX_WIDTH);
    else eff_width = img_w_r;
    if (img_h_r == 13'd0) eff_height = 13'd1;
    else if (img_h_r > 13'(mlwf_pkg::MAX_HEIGHT)) eff_height = 13'(mlwf_pkg::MAX_HEIGHT);
    else eff_height = img_h_r;
  end

  assign in_stall = !idle;
  assign in_acc   = in_valid && !in_stall;
  assign out_full = out_valid_r && out_stall;

  mlwf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_acc   (in_acc),
    .out_full (out_full),
    .sts      (sts),
    .cmd      (cmd),
    .idle     (idle)
  );

  mlwf_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .eff_width  (eff_width),
    .eff_height (eff_height),
    .mode       (mode_r),
    .win_w      (win_w_r),
    .win_h      (win_h_r),
    .in_red     (in_red),
    .in_green   (in_green),
    .in_blue    (in_blue),
    .res_row    (res_row),
    .res_col    (res_col),
    .res_red    (res_red),
    .res_green  (res_green),
    .res_blue   (res_blue)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_row_r   <= res_row;
      out_col_r   <= res_col;
      out_red_r   <= res_red;
      out_green_r <= res_green;
      out_blue_r  <= res_blue;
    end
  end

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

  `MLWF_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall)
  `MLWF_ASSERT(a_result_from_work, $rose(out_valid) |-> $past(in_stall))
  `MLWF_ASSERT(a_no_overwrite, cmd.out_load |-> !(out_valid_r && out_stall))
  `MLWF_ASSERT_ALWAYS(a_size_nonzero, rst_n |-> eff_width != 11'd0 && eff_height != 13'd0)
endmodule

// ----- tb/mean_and_laplacian_window_filter_test.sv -----
`timescale 1ns / 100ps
module mean_and_laplacian_window_filter_test;

  localparam logic MODE_MEAN = 1'b0;
  localparam logic MODE_LAPLACE = 1'b1;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_WIDTH = mlwf_pkg::MAX_WIDTH;
  localparam int MAX_HEIGHT = mlwf_pkg::MAX_HEIGHT;
  localparam int MAX_WINDOW = mlwf_pkg::MAX_WINDOW;
  localparam int LINE_ROWS = mlwf_pkg::LINE_ROWS;

  typedef struct packed {
    logic [11:0] row;
    logic [9:0]  col;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } centre_px_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_red;
  logic [7:0]  in_green;
  logic [7:0]  in_blue;
  logic        out_valid;
  logic        out_stall;
  logic [11:0] out_row;
  logic [9:0]  out_col;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [12:0] cfg_data;

  // predictor state
  logic [23:0] row_mem [0:MAX_WIDTH*LINE_ROWS-1];
  logic [23:0] win_px [0:MAX_WINDOW-1][0:MAX_WINDOW-1];  // [column age][row age]
  int          next_col;
  int          next_row;
  logic [10:0] img_w_reg;
  logic [12:0] img_h_reg;
  logic        mode_reg;
  logic [2:0]  win_w_reg;
  logic [2:0]  win_h_reg;

  centre_px_t  pending_px[$];
  int          err_count;
  int          px_sent;
  int          px_filtered;
  int          frame_count;
  int          tx_idle_max;
  int          rx_idle_max;
  int          rx_hold_cycles;

  mean_and_laplacian_window_filter u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_row(out_row), .out_col(out_col),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // 12 ns clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic int fit_range(input int v, input int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int chan_of(input logic [23:0] p, input int ch);
    return int'(p[8*ch +: 8]);
  endfunction

  // Model one accepted pixel; queue the centre it completes, if any.
  function automatic void filter_pixel(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
    int ew, eh, rr, cc, base, kx, ky, ox, oy, ci, rj, ch, sum, v, ctr, nb;
    logic [23:0] pix;
    logic [23:0] col_v [0:MAX_WINDOW-1];
    int res [0:2];
    centre_px_t e;
    ew = fit_range(int'(img_w_reg), MAX_WIDTH);
    eh = fit_range(int'(img_h_reg), MAX_HEIGHT);
    rr = next_row;
    cc = next_col;
    pix = {b, g, r};
    base = cc * LINE_ROWS;
    col_v[0] = pix;
    for (int k = 1; k < MAX_WINDOW; k++) col_v[k] = row_mem[base + k - 1];
    for (ci = MAX_WINDOW - 1; ci > 0; ci--)
      for (rj = 0; rj < MAX_WINDOW; rj++) win_px[ci][rj] = win_px[ci-1][rj];
    for (rj = 0; rj < MAX_WINDOW; rj++) win_px[0][rj] = col_v[rj];
    for (int k = LINE_ROWS - 1; k > 0; k--) row_mem[base + k] = row_mem[base + k - 1];
    row_mem[base] = pix;

    // raster position
    next_col = cc + 1;
    if (next_col >= ew) begin
      next_col = 0;
      next_row = rr + 1;
      if (next_row >= eh) next_row = 0;
    end

    if (mode_reg == MODE_LAPLACE) begin
      kx = 3;
      ky = 3;
    end else begin
      kx = fit_range(int'(win_w_reg), MAX_WINDOW);
      ky = fit_range(int'(win_h_reg), MAX_WINDOW);
    end
    ox = kx / 2;
    oy = ky / 2;
    if (rr < ky - 1 || cc < kx - 1) return;
    e.row = 12'(rr - (ky - 1) + oy);
    e.col = 10'(cc - (kx - 1) + ox);
    if (int'(e.col) + ox >= ew || int'(e.row) + oy >= eh) return;

    for (ch = 0; ch < 3; ch++) begin
      if (mode_reg == MODE_LAPLACE) begin
        ctr = chan_of(win_px[1][1], ch);
        nb = chan_of(win_px[1][0], ch) + chan_of(win_px[1][2], ch) +
             chan_of(win_px[0][1], ch) + chan_of(win_px[2][1], ch);
        v = 5 * ctr - nb;
        if (v > 255) v = 255;
        if (v < 0) v = 0;
        res[ch] = v;
      end else begin
        sum = 0;
        for (ci = 0; ci < kx; ci++)
          for (rj = 0; rj < ky; rj++) sum += chan_of(win_px[ci][rj], ch);
        res[ch] = sum / (kx * ky);
      end
    end
    e.red = 8'(res[0]);
    e.green = 8'(res[1]);
    e.blue = 8'(res[2]);
    pending_px.push_back(e);
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  // input beats and register writes feed the predictor
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      filter_pixel(in_red, in_green, in_blue);
      px_sent++;
    end
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        mlwf_pkg::CFG_IMAGE_WIDTH:   img_w_reg = cfg_data[10:0];
        mlwf_pkg::CFG_IMAGE_HEIGHT:  img_h_reg = cfg_data;
        mlwf_pkg::CFG_FILTER_MODE:   mode_reg = cfg_data[0];
        mlwf_pkg::CFG_WINDOW_WIDTH:  win_w_reg = cfg_data[2:0];
        mlwf_pkg::CFG_WINDOW_HEIGHT: win_h_reg = cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    centre_px_t e;
    if (rst_n && out_valid && !out_stall) begin
      px_filtered++;
      if (pending_px.size() == 0) begin
        report_mismatch($sformatf("unexpected beat row %0d col %0d", out_row, out_col));
      end else begin
        e = pending_px.pop_front();
        if (out_row !== e.row)
          report_mismatch($sformatf("row got %0d exp %0d", out_row, e.row));
        if (out_col !== e.col)
          report_mismatch($sformatf("col got %0d exp %0d", out_col, e.col));
        if (out_red !== e.red)
          report_mismatch($sformatf("red @(%0d,%0d) got %0d exp %0d",
                                    e.row, e.col, out_red, e.red));
        if (out_green !== e.green)
          report_mismatch($sformatf("green @(%0d,%0d) got %0d exp %0d",
                                    e.row, e.col, out_green, e.green));
        if (out_blue !== e.blue)
          report_mismatch($sformatf("blue @(%0d,%0d) got %0d exp %0d",
                                    e.row, e.col, out_blue, e.blue));
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int n;
    out_stall <= 1'b1;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        n = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        n = $urandom_range(0, rx_idle_max);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Send one pixel; valid stays high on return so back-to-back beats never drop it.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, tx_idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Lower valid and wait until every expected beat is out and the block is quiet.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // valid is left high; the caller lowers it after the last write
  task automatic write_reg(input logic [2:0] idx, input logic [12:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_frame(input int w, input int h, input logic mode,
                           input int kw, input int kh);
    drain();
    write_reg(mlwf_pkg::CFG_IMAGE_WIDTH, 13'(w));
    write_reg(mlwf_pkg::CFG_IMAGE_HEIGHT, 13'(h));
    write_reg(mlwf_pkg::CFG_FILTER_MODE, 13'(mode));
    write_reg(mlwf_pkg::CFG_WINDOW_WIDTH, 13'(kw));
    write_reg(mlwf_pkg::CFG_WINDOW_HEIGHT, 13'(kh));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // one whole frame of random pixels, so counters end back at the origin
  task automatic random_frame();
    int n;
    n = fit_range(int'(img_w_reg), MAX_WIDTH) * fit_range(int'(img_h_reg), MAX_HEIGHT);
    for (int i = 0; i < n; i++) send_pixel(pick_level(), pick_level(), pick_level());
    frame_count++;
  endtask

  // Laplacian on a checkerboard: both clamp ends on every channel
  task automatic test_laplace_clamp();
    logic [7:0] lv;
    tx_idle_max = 15;
    rx_idle_max = 15;
    set_frame(4, 4, MODE_LAPLACE, 3, 3);
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) begin
        lv = ((r + c) % 2 == 0) ? 8'hFF : 8'h00;
        send_pixel(lv, ~lv, (c == 1) ? 8'h80 : lv);
      end
    frame_count++;
  endtask

  // small frames across modes and window shapes, with and without idling
  task automatic test_window_sweep();
    int target;
    target = px_sent + 500;
    while (px_sent < target) begin
      tx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
      rx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
      set_frame($urandom_range(1, 12), $urandom_range(1, 10),
                ($urandom_range(0, 2) == 0) ? MODE_LAPLACE : MODE_MEAN,
                $urandom_range(0, 7), $urandom_range(0, 7));
      random_frame();
    end
  endtask

  // widest row: width field saturated acts as the maximum
  task automatic test_wide_row();
    tx_idle_max = 2;
    rx_idle_max = 2;
    set_frame(13'h1FFF, 1, MODE_MEAN, 7, 1);
    random_frame();
  endtask

  // top of the tallest frame: height saturated, width and window width zero act as one
  task automatic test_tall_column();
    tx_idle_max = 1;
    rx_idle_max = 1;
    set_frame(0, 13'h1FFF, MODE_MEAN, 0, 7);
    for (int i = 0; i < 200; i++) send_pixel(pick_level(), pick_level(), pick_level());
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    tx_idle_max = 0;
    rx_idle_max = 0;
    set_frame(8, 8, MODE_MEAN, 1, 1);
    rx_hold_cycles = 400;
    random_frame();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_red <= 8'h00;
    in_green <= 8'h00;
    in_blue <= 8'h00;
    cfg_valid <= 1'b0;
    cfg_index <= mlwf_pkg::CFG_IMAGE_WIDTH;
    cfg_data <= 13'h0000;
    err_count = 0;
    px_sent = 0;
    px_filtered = 0;
    frame_count = 0;
    tx_idle_max = 15;
    rx_idle_max = 15;
    rx_hold_cycles = 0;
    next_col = 0;
    next_row = 0;
    img_w_reg = 11'd640;
    img_h_reg = 13'd480;
    mode_reg = MODE_MEAN;
    win_w_reg = 3'd3;
    win_h_reg = 3'd3;
    for (int i = 0; i < MAX_WIDTH * LINE_ROWS; i++) row_mem[i] = '0;
    for (int i = 0; i < MAX_WINDOW; i++)
      for (int j = 0; j < MAX_WINDOW; j++) win_px[i][j] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_laplace_clamp();
    test_backpressure();
    test_window_sweep();
    test_wide_row();
    test_tall_column();
    drain();

    if (pending_px.size() != 0)
      report_mismatch($sformatf("%0d beats never arrived", pending_px.size()));
    $display("Covered %0d frames, %0d pixels in, %0d filtered beats out.",
             frame_count, px_sent, px_filtered);
    $display("Mean windows 1..7 incl. zero sizes, Laplacian clamps, saturated sizes, hold-off.");
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/mlwf_pkg.sv
design/mlwf_ctrl.sv
design/mlwf_dp.sv
design/mean_and_laplacian_window_filter.sv
tb/mean_and_laplacian_window_filter_test.sv
